// ----- design/smstep_pkg.sv -----
package smstep_pkg;

    localparam int unsigned StackDepth   = 1024;
    localparam int unsigned ProgramDepth = 1024;
    localparam int unsigned SpW          = $clog2(StackDepth);
    localparam int unsigned PaW          = $clog2(ProgramDepth);
    localparam int unsigned CntW         = 11;

    typedef enum logic [3:0] {
        K_PUSH  = 4'd0,
        K_DUP   = 4'd1,
        K_PLUS  = 4'd2,
        K_MINUS = 4'd3,
        K_MUL   = 4'd4,
        K_DIV   = 4'd5,
        K_JMP   = 4'd6,
        K_JIT   = 4'd7,
        K_EQ    = 4'd8,
        K_END   = 4'd9,
        K_PRINT = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        E_OK       = 3'd0,
        E_OVERFLOW = 3'd1,
        E_UNDER    = 3'd2,
        E_ILLEGAL  = 3'd3,
        E_DIVZERO  = 3'd4,
        E_OPERAND  = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        A_MUL = 2'd0,
        A_DIV = 2'd1
    } t_aop;

    // Request to and status from the shared multicycle arithmetic unit.
    typedef struct packed {
        logic        start;
        t_aop        op;
    } t_alu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
    } t_alu_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_READB,
        S_READA,
        S_EXEC,
        S_WAIT,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

// ----- design/stack_machine_step_core.sv -----
// Stack machine step core.
// An input item on the i_ channel (valid/ready) either loads one program word
// (opcode 0) or executes the instruction at the program counter (opcode 1).
// Each item produces exactly one result item on the o_ channel (valid/ready)
// holding the error code, halt flag, print data, program counter and stack count.
// The configuration channel writes program_length; it is always ready.
// The block takes one item at a time. A load goes straight to the result; a
// step passes through the program store read, up to two stack reads and a
// stack write, or goes straight to the result when the program counter is out
// of range. Multiply and divide go through a shared bit-serial unit.
// Reset clears the program counter, stack count, halt flag and program_length.
// The program store and data stack are not cleared; reading unwritten words is
// undefined. The result is held in an output register while the receiver
// stalls, and no new item is accepted until the result has been taken.
module stack_machine_step_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_opcode,
    input  logic [9:0]   i_word_address,
    input  logic [3:0]   i_word_kind,
    input  logic [63:0]  i_word_operand,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [9:0]   i_cfg_program_length,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [2:0]   o_error_code,
    output logic         o_halted,
    output logic         o_print_valid,
    output logic [63:0]  o_print_value,
    output logic [63:0]  o_program_counter,
    output logic [10:0]  o_stack_count
);

    localparam int unsigned SpW = smstep_pkg::SpW;
    localparam int unsigned PaW = smstep_pkg::PaW;

    smstep_pkg::t_state r_state, n_state;

    logic [9:0]   r_plen;
    logic [63:0]  r_pc, n_pc;
    logic [10:0]  r_cnt, n_cnt;
    logic         r_end, n_end;

    // Program store and data stack memories.
    logic [67:0]  r_code [smstep_pkg::ProgramDepth];
    logic [63:0]  r_stack [smstep_pkg::StackDepth];
    logic [67:0]  r_code_q;
    logic [63:0]  r_stack_q;

    logic         w_code_we;
    logic [PaW-1:0] w_code_wa;
    logic         w_st_we;
    logic [SpW-1:0] w_st_wa;
    logic [SpW-1:0] w_st_ra;
    logic [63:0]  w_st_wd;

    logic [3:0]   r_kind, n_kind;
    logic [63:0]  r_opd, n_opd;
    logic [63:0]  r_a, n_a;
    logic [63:0]  r_b, n_b;
    logic [63:0]  r_wd, n_wd;

    logic [2:0]   r_err, n_err;
    logic         r_pv, n_pv;
    logic [63:0]  r_pval, n_pval;

    smstep_pkg::t_alu_req w_req;
    smstep_pkg::t_alu_sts w_sts;
    logic [63:0]  w_alu;

    smstep_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_sts   (w_sts),
        .o_res   (w_alu)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == smstep_pkg::S_IDLE);
    assign o_valid = (r_state == smstep_pkg::S_OUT);

    always_ff @(posedge i_clk) begin
        if (w_code_we) begin
            r_code[w_code_wa] <= {i_word_kind, i_word_operand};
        end
        r_code_q <= r_code[r_pc[PaW-1:0]];
        if (w_st_we) begin
            r_stack[w_st_wa] <= w_st_wd;
        end
        r_stack_q <= r_stack[w_st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smstep_pkg::S_IDLE;
            r_plen  <= 10'd0;
            r_pc    <= 64'd0;
            r_cnt   <= 11'd0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_plen <= i_cfg_program_length;
            end
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
            r_end <= n_end;
        end
        r_kind <= n_kind;
        r_opd  <= n_opd;
        r_a    <= n_a;
        r_b    <= n_b;
        r_wd   <= n_wd;
        r_err  <= n_err;
        r_pv   <= n_pv;
        r_pval <= n_pval;
    end

    logic [10:0] w_dup_idx;
    logic        w_binop;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        n_end   = r_end;
        n_kind  = r_kind;
        n_opd   = r_opd;
        n_a     = r_a;
        n_b     = r_b;
        n_wd    = r_wd;
        n_err   = r_err;
        n_pv    = r_pv;
        n_pval  = r_pval;
        w_code_we = 1'b0;
        w_code_wa = i_word_address[PaW-1:0];
        w_st_we = 1'b0;
        w_st_wa = r_cnt[SpW-1:0];
        w_st_ra = r_cnt[SpW-1:0] - SpW'(1);
        w_st_wd = r_wd;
        w_req.start = 1'b0;
        w_req.op = (r_kind == smstep_pkg::K_DIV) ? smstep_pkg::A_DIV : smstep_pkg::A_MUL;
        w_dup_idx = r_cnt - 11'd1 - r_opd[10:0];
        w_binop = (r_kind inside {smstep_pkg::K_PLUS, smstep_pkg::K_MINUS,
                                  smstep_pkg::K_MUL, smstep_pkg::K_DIV,
                                  smstep_pkg::K_JIT, smstep_pkg::K_EQ,
                                  smstep_pkg::K_PRINT});
        case (r_state)
            smstep_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_err  = smstep_pkg::E_OK;
                    n_pv   = 1'b0;
                    n_pval = 64'd0;
                    if (!i_opcode) begin
                        w_code_we = 1'b1;
                        n_state = smstep_pkg::S_OUT;
                    end else if (r_pc[63] || r_pc >= {54'd0, r_plen}) begin
                        n_err = smstep_pkg::E_ILLEGAL;
                        n_state = smstep_pkg::S_OUT;
                    end else begin
                        n_state = smstep_pkg::S_FETCH;
                    end
                end
            end
            smstep_pkg::S_FETCH: begin
                // Store read data is registered this cycle.
                n_state = smstep_pkg::S_DECODE;
            end
            smstep_pkg::S_DECODE: begin
                n_kind = r_code_q[67:64];
                n_opd  = r_code_q[63:0];
                n_state = smstep_pkg::S_READB;
            end
            smstep_pkg::S_READB: begin
                // Stack read of the top, or of the dup source.
                n_state = smstep_pkg::S_READA;
                if (r_kind == smstep_pkg::K_PUSH) begin
                    if (r_cnt >= 11'(smstep_pkg::StackDepth)) begin
                        n_err = smstep_pkg::E_OVERFLOW;
                        n_state = smstep_pkg::S_OUT;
                    end else begin
                        n_wd = r_opd;
                        n_state = smstep_pkg::S_WRITE;
                    end
                end else if (r_kind == smstep_pkg::K_DUP) begin
                    if (r_cnt >= 11'(smstep_pkg::StackDepth)) begin
                        n_err = smstep_pkg::E_OVERFLOW;
                        n_state = smstep_pkg::S_OUT;
                    end else if (r_opd[63]) begin
                        n_err = smstep_pkg::E_OPERAND;
                        n_state = smstep_pkg::S_OUT;
                    end else if (r_opd >= {53'd0, r_cnt}) begin
                        n_err = smstep_pkg::E_UNDER;
                        n_state = smstep_pkg::S_OUT;
                    end else begin
                        w_st_ra = w_dup_idx[SpW-1:0];
                    end
                end else if (r_kind == smstep_pkg::K_JMP) begin
                    n_pc = r_opd;
                    n_state = smstep_pkg::S_OUT;
                end else if (r_kind == smstep_pkg::K_END) begin
                    n_end = 1'b1;
                    n_state = smstep_pkg::S_OUT;
                end else if (!w_binop) begin
                    n_err = smstep_pkg::E_ILLEGAL;
                    n_state = smstep_pkg::S_OUT;
                end else if (r_cnt < 11'd2) begin
                    n_err = smstep_pkg::E_UNDER;
                    n_state = smstep_pkg::S_OUT;
                end
            end
            smstep_pkg::S_READA: begin
                // r_stack_q holds top (or dup source); issue read of second.
                w_st_ra = r_cnt[SpW-1:0] - SpW'(2);
                if (r_kind == smstep_pkg::K_DUP) begin
                    n_wd = r_stack_q;
                    n_state = smstep_pkg::S_WRITE;
                end else begin
                    n_b = r_stack_q;
                    n_state = smstep_pkg::S_EXEC;
                end
            end
            smstep_pkg::S_EXEC: begin
                n_a = r_stack_q;
                n_state = smstep_pkg::S_WRITE;
                case (r_kind)
                    smstep_pkg::K_JIT: begin
                        if (r_b != 64'd0) begin
                            n_cnt = r_cnt - 11'd1;
                            n_pc = r_opd;
                        end else begin
                            n_pc = r_pc + 64'd1;
                        end
                        n_state = smstep_pkg::S_OUT;
                    end
                    smstep_pkg::K_PRINT: begin
                        n_pv = 1'b1;
                        n_pval = r_b;
                        n_cnt = r_cnt - 11'd1;
                        n_pc = r_pc + 64'd1;
                        n_state = smstep_pkg::S_OUT;
                    end
                    smstep_pkg::K_PLUS:  n_wd = r_stack_q + r_b;
                    smstep_pkg::K_MINUS: n_wd = r_stack_q - r_b;
                    smstep_pkg::K_EQ:    n_wd = {63'd0, r_stack_q == r_b};
                    smstep_pkg::K_DIV: begin
                        if (r_b == 64'd0) begin
                            n_err = smstep_pkg::E_DIVZERO;
                            n_state = smstep_pkg::S_OUT;
                        end else begin
                            n_state = smstep_pkg::S_WAIT;
                        end
                    end
                    default: n_state = smstep_pkg::S_WAIT;
                endcase
            end
            smstep_pkg::S_WAIT: begin
                // r_a and r_b are stable here; start then wait for done.
                if (!w_sts.busy && !w_sts.done) begin
                    w_req.start = 1'b1;
                end
                if (w_sts.done) begin
                    n_wd = w_alu;
                    n_state = smstep_pkg::S_WRITE;
                end
            end
            smstep_pkg::S_WRITE: begin
                w_st_we = 1'b1;
                if (r_kind == smstep_pkg::K_PUSH || r_kind == smstep_pkg::K_DUP) begin
                    w_st_wa = r_cnt[SpW-1:0];
                    n_cnt = r_cnt + 11'd1;
                end else begin
                    w_st_wa = r_cnt[SpW-1:0] - SpW'(2);
                    n_cnt = r_cnt - 11'd1;
                end
                n_pc = r_pc + 64'd1;
                n_state = smstep_pkg::S_OUT;
            end
            smstep_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = smstep_pkg::S_IDLE;
                end
            end
            default: n_state = smstep_pkg::S_IDLE;
        endcase
    end

    assign o_error_code      = r_err;
    assign o_halted          = r_end;
    assign o_print_valid     = r_pv;
    assign o_print_value     = r_pval;
    assign o_program_counter = r_pc;
    assign o_stack_count     = r_cnt;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 11'(smstep_pkg::StackDepth)) else $error("stack count overrun");
    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_err != smstep_pkg::E_OK) |-> (r_cnt == $past(r_cnt) || !$past(o_valid)))
        else $error("state moved on error");
    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_end) |-> r_end) else $error("halt flag cleared");

endmodule

// ----- design/smstep_alu.sv -----
module smstep_alu (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  smstep_pkg::t_alu_req     i_req,
    input  logic [63:0]              i_a,
    input  logic [63:0]              i_b,
    output smstep_pkg::t_alu_sts     o_sts,
    output logic [63:0]              o_res
);

    // Multiply: radix-2 shift and add, 64 steps.
    // Divide: restoring division on magnitudes, 64 steps, sign fixed at the end.
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_div, n_div;
    logic        r_neg, n_neg;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_x, n_x;
    logic [63:0] r_y, n_y;
    logic [64:0] w_trial;
    logic [63:0] w_rem;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_div  = r_div;
        n_neg  = r_neg;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        w_rem  = 64'd0;
        w_trial = 65'd0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd0;
            n_div  = (i_req.op == smstep_pkg::A_DIV);
            n_acc  = 64'd0;
            if (i_req.op == smstep_pkg::A_DIV) begin
                n_neg = i_a[63] ^ i_b[63];
                n_x   = i_a[63] ? (64'd0 - i_a) : i_a;
                n_y   = i_b[63] ? (64'd0 - i_b) : i_b;
            end else begin
                n_neg = 1'b0;
                n_x   = i_a;
                n_y   = i_b;
            end
        end else if (r_busy) begin
            if (r_div) begin
                // r_acc holds the remainder, r_x shifts quotient bits in.
                w_rem   = {r_acc[62:0], r_x[63]};
                w_trial = {1'b0, w_rem} - {1'b0, r_y};
                if (!w_trial[64] || r_acc[63]) begin
                    n_acc = w_trial[63:0];
                    n_x   = {r_x[62:0], 1'b1};
                end else begin
                    n_acc = w_rem;
                    n_x   = {r_x[62:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x = {r_x[62:0], 1'b0};
                n_y = {1'b0, r_y[63:1]};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_neg <= n_neg;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res = r_div ? (r_neg ? (64'd0 - r_x) : r_x) : r_acc;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("alu done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done) else $error("alu busy and done together");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_cnt == 7'd0) else $error("alu count not cleared");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // One expected result item.
    typedef struct {
        smstep_pkg::t_err err;
        logic        halted;
        logic        pv;
        logic [63:0] pval;
        logic [63:0] pc;
        logic [10:0] cnt;
    } t_step_result;

    // Tracks the machine state and holds the results still to come.
    class t_machine_tracker;
        logic [63:0]  stack_mem [smstep_pkg::StackDepth];
        logic [3:0]   kind_mem [smstep_pkg::ProgramDepth];
        logic [63:0]  opd_mem [smstep_pkg::ProgramDepth];
        bit           written [smstep_pkg::ProgramDepth];
        int unsigned  depth;
        logic [63:0]  pc;
        logic         halted;
        logic [9:0]   plen;
        t_step_result pending_results [$];
        int           mismatches;

        function void clear();
            depth = 0;
            pc = '0;
            halted = 1'b0;
            plen = '0;
            mismatches = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        // Executes one instruction; an error returns before any state changes.
        function smstep_pkg::t_err run_step(output logic pv, output logic [63:0] pval);
            logic [63:0] a, b, opd, ma, mb, q;
            logic [3:0]  k;
            int unsigned n;
            pv = 1'b0;
            pval = '0;
            n = depth;
            if (pc[63] || pc >= {54'd0, plen} || pc >= smstep_pkg::ProgramDepth)
                return smstep_pkg::E_ILLEGAL;
            k = kind_mem[pc[9:0]];
            opd = opd_mem[pc[9:0]];
            case (k)
                smstep_pkg::K_PUSH: begin
                    if (n >= smstep_pkg::StackDepth) return smstep_pkg::E_OVERFLOW;
                    stack_mem[n] = opd;
                    depth = n + 1;
                    pc = pc + 1;
                    return smstep_pkg::E_OK;
                end
                smstep_pkg::K_DUP: begin
                    if (n >= smstep_pkg::StackDepth) return smstep_pkg::E_OVERFLOW;
                    if (opd[63]) return smstep_pkg::E_OPERAND;
                    if (opd >= n) return smstep_pkg::E_UNDER;
                    stack_mem[n] = stack_mem[n - 1 - opd[31:0]];
                    depth = n + 1;
                    pc = pc + 1;
                    return smstep_pkg::E_OK;
                end
                smstep_pkg::K_JMP: begin
                    pc = opd;
                    return smstep_pkg::E_OK;
                end
                smstep_pkg::K_END: begin
                    halted = 1'b1;
                    return smstep_pkg::E_OK;
                end
                smstep_pkg::K_PLUS, smstep_pkg::K_MINUS, smstep_pkg::K_MUL,
                smstep_pkg::K_DIV, smstep_pkg::K_JIT, smstep_pkg::K_EQ,
                smstep_pkg::K_PRINT: ;
                default: return smstep_pkg::E_ILLEGAL;
            endcase
            if (n < 2) return smstep_pkg::E_UNDER;
            a = stack_mem[n - 2];
            b = stack_mem[n - 1];
            case (k)
                smstep_pkg::K_JIT: begin
                    if (b != 0) begin
                        depth = n - 1;
                        pc = opd;
                    end else begin
                        pc = pc + 1;
                    end
                    return smstep_pkg::E_OK;
                end
                smstep_pkg::K_PRINT: begin
                    pv = 1'b1;
                    pval = b;
                    depth = n - 1;
                    pc = pc + 1;
                    return smstep_pkg::E_OK;
                end
                smstep_pkg::K_DIV: begin
                    if (b == 0) return smstep_pkg::E_DIVZERO;
                    // Divide magnitudes, then fix the sign; MIN / -1 wraps to MIN.
                    ma = a[63] ? -a : a;
                    mb = b[63] ? -b : b;
                    q = ma / mb;
                    a = (a[63] != b[63]) ? -q : q;
                end
                smstep_pkg::K_PLUS: a = a + b;
                smstep_pkg::K_MINUS: a = a - b;
                smstep_pkg::K_MUL: a = a * b;
                default: a = (a == b) ? 64'd1 : 64'd0;
            endcase
            stack_mem[n - 2] = a;
            depth = n - 1;
            pc = pc + 1;
            return smstep_pkg::E_OK;
        endfunction

        function void note_item(logic op, logic [9:0] addr, logic [3:0] kind,
                                logic [63:0] opd);
            t_step_result r;
            r.err = smstep_pkg::E_OK;
            r.pv = 1'b0;
            r.pval = '0;
            if (!op) begin
                kind_mem[addr] = kind;
                opd_mem[addr] = opd;
                written[addr] = 1'b1;
            end else begin
                r.err = run_step(r.pv, r.pval);
            end
            r.halted = halted;
            r.pc = pc;
            r.cnt = depth[10:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [2:0] err, logic h, logic pv, logic [63:0] pval,
                                   logic [63:0] rpc, logic [10:0] cnt);
            t_step_result e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item, pc %0d", rpc);
                return;
            end
            e = pending_results.pop_front();
            if (err !== e.err || h !== e.halted || pv !== e.pv || pval !== e.pval ||
                rpc !== e.pc || cnt !== e.cnt) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp err %0d halt %0b pv %0b pval %h pc %h cnt %0d",
                             e.err, e.halted, e.pv, e.pval, e.pc, e.cnt);
                    $display("         got err %0d halt %0b pv %0b pval %h pc %h cnt %0d",
                             err, h, pv, pval, rpc, cnt);
                end
            end
        endfunction
    endclass

    localparam int CycleLimit = 1000000;
    localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_opcode;
    logic [9:0]  i_word_address;
    logic [3:0]  i_word_kind;
    logic [63:0] i_word_operand;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [9:0]  i_cfg_program_length;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_error_code;
    logic        o_halted;
    logic        o_print_valid;
    logic [63:0] o_print_value;
    logic [63:0] o_program_counter;
    logic [10:0] o_stack_count;

    t_machine_tracker machine;
    int tx_idle;
    int rx_idle;
    int cycles;

    stack_machine_step_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_word_address(i_word_address),
        .i_word_kind(i_word_kind),
        .i_word_operand(i_word_operand),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_program_length(i_cfg_program_length),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_error_code(o_error_code),
        .o_halted(o_halted),
        .o_print_valid(o_print_valid),
        .o_print_value(o_print_value),
        .o_program_counter(o_program_counter),
        .o_stack_count(o_stack_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls at random; a result item is taken when valid and
    // ready were both high at the edge. Values read here are the ones the
    // edge saw, since all drivers use nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            machine.check_result(o_error_code, o_halted, o_print_valid, o_print_value,
                                 o_program_counter, o_stack_count);
        i_ready <= ($urandom_range(99) >= rx_idle);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sends one input item. Idle cycles come before valid rises, so valid is
    // never dropped and raised in the same step.
    task send_item(input logic op, input logic [9:0] addr, input logic [3:0] kind,
                   input logic [63:0] opd);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_word_address <= addr;
        i_word_kind <= kind;
        i_word_operand <= opd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        machine.note_item(op, addr, kind, opd);
    endtask

    // Holds off the sender until every expected result item has arrived.
    task drain();
        i_valid <= 1'b0;
        while (machine.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes program_length while the block is idle.
    task write_length(input int unsigned len);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_program_length <= len[9:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        machine.plen = len[9:0];
    endtask

    // Loads the given word at the program counter, then executes it.
    task run_word(input logic [3:0] kind, input logic [63:0] opd);
        send_item(1'b0, machine.pc[9:0], kind, opd);
        send_item(1'b1, '0, '0, '0);
    endtask

    function logic [63:0] rand_value();
        case ($urandom_range(7))
            0: return '0;
            1: return 64'($urandom_range(3));
            2: return MinVal;
            3: return MaxVal;
            4: return '1;
            5: return -64'($urandom_range(3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Picks a random program word. Jump targets stay inside the program so
    // that the program counter never leaves it for good.
    task rand_word(output logic [3:0] kind, output logic [63:0] opd);
        int r;
        r = $urandom_range(99);
        if (r < 22) kind = smstep_pkg::K_PUSH;
        else if (r < 30) kind = smstep_pkg::K_DUP;
        else if (r < 40) kind = smstep_pkg::K_PLUS;
        else if (r < 48) kind = smstep_pkg::K_MINUS;
        else if (r < 55) kind = smstep_pkg::K_MUL;
        else if (r < 62) kind = smstep_pkg::K_DIV;
        else if (r < 67) kind = smstep_pkg::K_JMP;
        else if (r < 75) kind = smstep_pkg::K_JIT;
        else if (r < 82) kind = smstep_pkg::K_EQ;
        else if (r < 84) kind = smstep_pkg::K_END;
        else if (r < 93) kind = smstep_pkg::K_PRINT;
        else kind = 4'($urandom_range(15, 11));
        case (kind)
            smstep_pkg::K_DUP: begin
                r = $urandom_range(19);
                if (r == 0) opd = {1'b1, 63'($urandom)};
                else if (r == 1) opd = {$urandom, $urandom};
                else opd = 64'($urandom_range(machine.depth + 1));
            end
            smstep_pkg::K_JMP, smstep_pkg::K_JIT: opd = 64'($urandom_range(machine.plen - 1));
            default: opd = rand_value();
        endcase
    endtask

    // One random item. Steps run only on written words, and the last word of
    // the program is always a jump so that execution wraps around.
    task random_item();
        logic [3:0] kind;
        logic [63:0] opd;
        int r;
        rand_word(kind, opd);
        r = $urandom_range(99);
        if (machine.pc >= machine.plen) begin
            send_item(1'b1, '0, '0, '0);
        end else if (machine.pc == machine.plen - 1 &&
                     !(machine.written[machine.pc[9:0]] &&
                       machine.kind_mem[machine.pc[9:0]] == smstep_pkg::K_JMP)) begin
            send_item(1'b0, machine.pc[9:0], smstep_pkg::K_JMP,
                      64'($urandom_range(machine.plen - 1)));
        end else if (!machine.written[machine.pc[9:0]] || r < 18) begin
            send_item(1'b0, machine.pc[9:0], kind, opd);
        end else if (r < 28) begin
            send_item(1'b0, 10'($urandom), kind, opd);
        end else begin
            send_item(1'b1, 10'($urandom), 4'($urandom), {$urandom, $urandom});
        end
    endtask

    // Picks a new program length that still covers the program counter.
    task new_length();
        int unsigned len;
        case ($urandom_range(2))
            0: len = 1023;
            1: len = $urandom_range(60, 8);
            default: len = $urandom_range(1023, 1);
        endcase
        if (len <= machine.pc) len = machine.pc + 1;
        write_length(len);
    endtask

    task random_phase(input int tx, input int rx);
        tx_idle = tx;
        rx_idle = rx;
        for (int p = 0; p < 5; p++) begin
            new_length();
            for (int i = 0; i < 50; i++) random_item();
        end
    endtask

    initial begin
        machine = new();
        machine.clear();
        tx_idle = 0;
        rx_idle = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_opcode <= 1'b0;
        i_word_address <= '0;
        i_word_kind <= '0;
        i_word_operand <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_program_length <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: wrapping add, MIN / -1, divide by zero, dup errors,
        // both outcomes of jump-if-true, print, an illegal kind and end.
        write_length(1023);
        run_word(smstep_pkg::K_PUSH, MaxVal);
        run_word(smstep_pkg::K_PUSH, 64'd1);
        run_word(smstep_pkg::K_PLUS, '0);
        run_word(smstep_pkg::K_PUSH, '1);
        run_word(smstep_pkg::K_DIV, '0);
        run_word(smstep_pkg::K_PLUS, '0);
        run_word(smstep_pkg::K_PUSH, '0);
        run_word(smstep_pkg::K_DIV, '0);
        run_word(smstep_pkg::K_MUL, '0);
        run_word(smstep_pkg::K_DUP, '1);
        run_word(smstep_pkg::K_DUP, 64'd5);
        run_word(smstep_pkg::K_DUP, '0);
        run_word(smstep_pkg::K_EQ, '0);
        run_word(smstep_pkg::K_PUSH, 64'd7);
        run_word(smstep_pkg::K_JIT, 64'd600);
        run_word(smstep_pkg::K_PUSH, '0);
        run_word(smstep_pkg::K_JIT, 64'd3);
        run_word(smstep_pkg::K_PRINT, '0);
        run_word(smstep_pkg::K_MINUS, '0);
        run_word(4'd12, '0);
        run_word(smstep_pkg::K_END, '0);
        run_word(smstep_pkg::K_JMP, 64'd5);
        // With no program words every step is illegal.
        write_length(0);
        send_item(1'b1, '0, '0, '0);

        random_phase(24, 63);
        random_phase(63, 24);
        random_phase(0, 0);

        write_length(1023);
        run_word(smstep_pkg::K_DUP, '0);
        // A negative program counter is illegal for good, so it comes last.
        run_word(smstep_pkg::K_JMP, -64'd3);
        send_item(1'b1, '0, '0, '0);

        drain();
        repeat (80) @(posedge i_clk);
        if (machine.mismatches == 0 && machine.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
